>>> src/tfr_pkg.sv
// ----------------------------------------------------------------------------
// tfr_pkg: shared types and helpers for the telegram frame receiver
// Item, result and configuration structs, code enums and the check update.
// ----------------------------------------------------------------------------
`default_nettype none

package tfr_pkg;

  // receive buffer size; a length field above the size less four is rejected at the command byte
  localparam int unsigned FRAME_BUFFER_BYTES = 1024;
  localparam logic [16:0] MAX_LENGTH         = 17'(FRAME_BUFFER_BYTES - 4);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_CODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NACK_CODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_ONLY   = 3'd4;

  // register reset values
  localparam logic [7:0]  START_CODE_RST = 8'h02;
  localparam logic [7:0]  ACK_CODE_RST   = 8'h06;
  localparam logic [7:0]  NACK_CODE_RST  = 8'h15;
  localparam logic [15:0] CRC_POLY_RST   = 16'h8005;

  // result kinds
  typedef enum logic [2:0] {
    KIND_BODY     = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_NACK     = 3'd2,
    KIND_GOOD     = 3'd3,
    KIND_CRC_BAD  = 3'd4,
    KIND_TOO_LONG = 3'd5,
    KIND_TIMEOUT  = 3'd6
  } kind_t;

  // receive phases
  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_BODY   = 2'd1,
    PH_CHK_LO = 2'd2,
    PH_CHK_HI = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  ack_code;
    logic [7:0]  nack_code;
    logic [15:0] crc_poly;
    logic        ack_only;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timed_out;
  } item_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [7:0]  address_byte;
    logic [15:0] frame_length;
    logic        last;
  } result_t;

  // one shift-and-xor check step over the new byte and the byte before it
  function automatic logic [15:0] crc_step(input logic [15:0] crc,
                                           input logic [7:0]  prev,
                                           input logic [7:0]  b,
                                           input logic [15:0] poly);
    logic [15:0] c;
    c = {crc[14:0], 1'b0};
    if (crc[15]) begin
      c = c ^ poly;
    end
    return c ^ {prev, b};
  endfunction

endpackage

`default_nettype wire

>>> src/telegram_frame_receiver.sv
// ----------------------------------------------------------------------------
// telegram_frame_receiver: start code / address / length / body / check deframer
// Hunts for ack, nack or a frame header in received bytes and streams the body
// followed by a verdict word.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake          payload
//   in_      slave      tvalid / tready    tdata rx_byte, tuser timed_out
//   out_     master     tvalid / tready    tdata body fields, tuser kind, tlast
//   cfg_     slave      valid / ready      index, data (16 bits)
//
// One word is taken per clock except while a result waits and out_tready is low;
// a word passes the input register, then the result register. The header check
// covers four header bytes and, for a nonzero length, the command byte, in the
// decode cycle. Reset clears the frame state and loads the register defaults
// at once; cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module telegram_frame_receiver #(
  parameter int unsigned FRAME_BUFFER_BYTES = tfr_pkg::FRAME_BUFFER_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,  // [7:0] rx_byte
  input  wire logic [0:0]                    in_tuser,  // [0] timed_out
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [7:0] data_byte, [17:8] byte_index, [25:18] address_byte,
  // [41:26] frame_length, [47:42] zero
  output logic [47:0]                        out_tdata,
  output logic [2:0]                         out_tuser, // [2:0] kind
  output logic                               out_tlast,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data
);

  tfr_pkg::cfg_t    cfg;
  tfr_pkg::item_t   in_item, item;
  tfr_pkg::result_t res;
  logic             item_valid, take;

  assign in_item.rx_byte   = in_tdata;
  assign in_item.timed_out = in_tuser[0];

  // core advances when the result register is free or draining
  assign take = item_valid && (!out_tvalid || out_tready);

  tfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  tfr_core #(
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .take  (take),
    .item  (item),
    .res   (res)
  );

  tfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> src/tfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// tfr_cfg_regs: configuration registers
// Holds start, ack and nack codes, check polynomial and ack-only mode.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                   cfg_data,
  output tfr_pkg::cfg_t                      cfg
);

  tfr_pkg::cfg_t cfg_r;
  logic          wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid;
  assign cfg       = cfg_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code <= tfr_pkg::START_CODE_RST;
      cfg_r.ack_code   <= tfr_pkg::ACK_CODE_RST;
      cfg_r.nack_code  <= tfr_pkg::NACK_CODE_RST;
      cfg_r.crc_poly   <= tfr_pkg::CRC_POLY_RST;
      cfg_r.ack_only   <= 1'b0;
    end else if (wr) begin
      case (cfg_index)
        tfr_pkg::CFG_START_CODE: cfg_r.start_code <= cfg_data[7:0];
        tfr_pkg::CFG_ACK_CODE:   cfg_r.ack_code   <= cfg_data[7:0];
        tfr_pkg::CFG_NACK_CODE:  cfg_r.nack_code  <= cfg_data[7:0];
        tfr_pkg::CFG_CRC_POLY:   cfg_r.crc_poly   <= cfg_data;
        tfr_pkg::CFG_ACK_ONLY:   cfg_r.ack_only   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/tfr_in_stage.sv
// ----------------------------------------------------------------------------
// tfr_in_stage: input register
// Captures one received word and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire tfr_pkg::item_t in_item,
  input  wire logic          take,
  output logic               item_valid,
  output tfr_pkg::item_t     item
);

  logic           valid_r;
  tfr_pkg::item_t item_r;

  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

>>> src/tfr_core.sv
// ----------------------------------------------------------------------------
// tfr_core: hunt, body and check state with its per-word decode
// Updates the frame state for each taken word and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_core #(
  parameter int unsigned FRAME_BUFFER_BYTES = tfr_pkg::FRAME_BUFFER_BYTES
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tfr_pkg::cfg_t  cfg,
  input  wire logic           take,
  input  wire tfr_pkg::item_t item,
  output tfr_pkg::result_t    res
);

  // longest length field that still fits the receive buffer
  localparam logic [16:0] MAX_LENGTH = 17'(FRAME_BUFFER_BYTES - 4);

  tfr_pkg::phase_t  phase_r, phase_nxt;
  logic [3:0][7:0]  win_r, win_nxt;
  logic [15:0]      count_r, count_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       addr_r, addr_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic [7:0]       clo_r, clo_nxt;

  logic [7:0]  b;
  logic        is_ack, is_nack, is_header, too_long, body_done, crc_match;
  logic [15:0] hdr_len, count_inc, hdr_crc4, hdr_crc5, body_crc;

  assign b         = item.rx_byte;
  assign is_ack    = (b == cfg.ack_code);
  assign is_nack   = (b == cfg.nack_code);
  assign is_header = !cfg.ack_only && (win_r[0] == cfg.start_code) && win_r[1][7];
  assign hdr_len   = {win_r[3], win_r[2]};
  assign too_long  = {1'b0, hdr_len} > MAX_LENGTH;
  assign count_inc = count_r + 16'd1;
  assign body_done = count_inc >= len_r;
  assign crc_match = ({b, clo_r} == crc_r);

  // check over the four header bytes, with and without the command byte
  always_comb begin
    logic [15:0] c;
    c = tfr_pkg::crc_step(16'h0000, 8'h00, win_r[0], cfg.crc_poly);
    c = tfr_pkg::crc_step(c, win_r[0], win_r[1], cfg.crc_poly);
    c = tfr_pkg::crc_step(c, win_r[1], win_r[2], cfg.crc_poly);
    c = tfr_pkg::crc_step(c, win_r[2], win_r[3], cfg.crc_poly);
    hdr_crc4 = c;
    hdr_crc5 = tfr_pkg::crc_step(c, win_r[3], b, cfg.crc_poly);
  end

  assign body_crc = tfr_pkg::crc_step(crc_r, prev_r, b, cfg.crc_poly);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (item.timed_out) begin
      phase_nxt = tfr_pkg::PH_HUNT;
    end else begin
      case (phase_r)
        tfr_pkg::PH_HUNT: begin
          if (!is_ack && !is_nack && is_header && !too_long) begin
            phase_nxt = (hdr_len > 16'd1) ? tfr_pkg::PH_BODY : tfr_pkg::PH_CHK_LO;
          end
        end
        tfr_pkg::PH_BODY:   if (body_done) phase_nxt = tfr_pkg::PH_CHK_LO;
        tfr_pkg::PH_CHK_LO: phase_nxt = tfr_pkg::PH_CHK_HI;
        tfr_pkg::PH_CHK_HI: phase_nxt = tfr_pkg::PH_HUNT;
        default:            phase_nxt = tfr_pkg::PH_HUNT;
      endcase
    end
  end

  // frame datapath next values
  always_comb begin
    logic clear;
    clear     = 1'b0;
    win_nxt   = win_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    addr_nxt  = addr_r;
    crc_nxt   = crc_r;
    prev_nxt  = prev_r;
    clo_nxt   = clo_r;
    if (item.timed_out) begin
      clear = 1'b1;
    end else begin
      case (phase_r)
        tfr_pkg::PH_HUNT: begin
          if (is_ack || is_nack) begin
            clear = 1'b1;
          end else if (is_header) begin
            if (too_long) begin
              clear = 1'b1;
            end else begin
              addr_nxt  = win_r[1];
              len_nxt   = hdr_len;
              count_nxt = 16'd1;
              if (hdr_len != 16'd0) begin
                crc_nxt  = hdr_crc5;
                prev_nxt = b;
              end else begin
                crc_nxt  = hdr_crc4;
                prev_nxt = win_r[3];
              end
            end
          end else begin
            win_nxt = {b, win_r[3], win_r[2], win_r[1]};
          end
        end
        tfr_pkg::PH_BODY: begin
          crc_nxt   = body_crc;
          prev_nxt  = b;
          count_nxt = count_inc;
        end
        tfr_pkg::PH_CHK_LO: clo_nxt = b;
        tfr_pkg::PH_CHK_HI: clear = 1'b1;
        default:            clear = 1'b1;
      endcase
    end
    if (clear) begin
      win_nxt   = '0;
      count_nxt = '0;
      len_nxt   = '0;
      addr_nxt  = '0;
      crc_nxt   = '0;
      prev_nxt  = '0;
      clo_nxt   = '0;
    end
  end

  // result for the taken word
  always_comb begin
    res              = '0;
    res.kind         = tfr_pkg::KIND_BODY;
    res.address_byte = addr_r;
    res.frame_length = len_r;
    if (item.timed_out) begin
      res.valid = 1'b1;
      res.kind  = tfr_pkg::KIND_TIMEOUT;
      res.last  = 1'b1;
    end else begin
      case (phase_r)
        tfr_pkg::PH_HUNT: begin
          if (is_ack || is_nack) begin
            res.valid     = 1'b1;
            res.kind      = is_ack ? tfr_pkg::KIND_ACK : tfr_pkg::KIND_NACK;
            res.data_byte = b;
            res.last      = 1'b1;
          end else if (is_header) begin
            res.valid        = 1'b1;
            res.data_byte    = b;
            res.address_byte = win_r[1];
            res.frame_length = hdr_len;
            if (too_long) begin
              res.kind = tfr_pkg::KIND_TOO_LONG;
              res.last = 1'b1;
            end
          end
        end
        tfr_pkg::PH_BODY: begin
          res.valid      = 1'b1;
          res.data_byte  = b;
          res.byte_index = count_r[9:0];
        end
        tfr_pkg::PH_CHK_HI: begin
          res.valid     = 1'b1;
          res.kind      = crc_match ? tfr_pkg::KIND_GOOD : tfr_pkg::KIND_CRC_BAD;
          res.data_byte = b;
          res.last      = 1'b1;
        end
        default: ;
      endcase
    end
    res.valid = res.valid && take;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tfr_pkg::PH_HUNT;
      win_r   <= '0;
      count_r <= '0;
      len_r   <= '0;
      addr_r  <= '0;
      crc_r   <= '0;
      prev_r  <= '0;
      clo_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      addr_r  <= addr_nxt;
      crc_r   <= crc_nxt;
      prev_r  <= prev_nxt;
      clo_r   <= clo_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/tfr_out_stage.sv
// ----------------------------------------------------------------------------
// tfr_out_stage: result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tfr_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tfr_pkg::result_t res,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [2:0]            out_tuser,
  output logic [47:0]           out_tdata,
  output logic                  out_tlast
);

  logic             valid_r;
  tfr_pkg::result_t res_r;

  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tlast  = res_r.last;
  assign out_tdata  = {6'b0, res_r.frame_length, res_r.address_byte,
                       res_r.byte_index, res_r.data_byte};

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

>>> sim/telegram_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// telegram_frame_receiver_tb: self-checking bench for the telegram deframer
// Drives received bytes and timeouts with random gaps and back-pressure,
// predicts every result word from a bit-exact model of the hunt, body and
// check logic, and compares the result stream field by field.
// ----------------------------------------------------------------------------

module telegram_frame_receiver_tb;

  // one expected result word
  typedef struct packed {
    tfr_pkg::kind_t kind;
    logic [7:0]     data_byte;
    logic [9:0]     byte_index;
    logic [7:0]     address_byte;
    logic [15:0]    frame_length;
    logic           last;
  } deframe_word_t;

  // predicts the result words of the deframer and checks the ones it sends
  class deframe_scoreboard;
    logic [7:0]      sof_code, ack_byte, nack_byte;
    logic [15:0]     poly;
    logic            ack_only;
    logic [7:0]      hunt_buf [4];
    tfr_pkg::phase_t ph;
    logic [15:0]     body_pos, len_field, run_check;
    logic [7:0]      addr_held, prev_rx, check_lo;
    deframe_word_t   due_words [$];
    int unsigned     n_fail, n_rx, n_counted, n_out;
    int unsigned     kind_seen [7];

    function new();
      sof_code  = tfr_pkg::START_CODE_RST;
      ack_byte  = tfr_pkg::ACK_CODE_RST;
      nack_byte = tfr_pkg::NACK_CODE_RST;
      poly      = tfr_pkg::CRC_POLY_RST;
      ack_only  = 1'b0;
      n_fail    = 0;
      n_rx      = 0;
      n_counted = 0;
      n_out     = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (hunt_buf[k]) hunt_buf[k] = 8'h00;
      ph        = tfr_pkg::PH_HUNT;
      body_pos  = 16'h0000;
      len_field = 16'h0000;
      addr_held = 8'h00;
      run_check = 16'h0000;
      prev_rx   = 8'h00;
      check_lo  = 8'h00;
    endfunction

    function void set_reg(logic [tfr_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        tfr_pkg::CFG_START_CODE: sof_code  = val[7:0];
        tfr_pkg::CFG_ACK_CODE:   ack_byte  = val[7:0];
        tfr_pkg::CFG_NACK_CODE:  nack_byte = val[7:0];
        tfr_pkg::CFG_CRC_POLY:   poly      = val;
        tfr_pkg::CFG_ACK_ONLY:   ack_only  = val[0];
        default: ;
      endcase
    endfunction

    // shift left, fold in the polynomial on carry, then xor the byte pair
    function void feed_check(logic [7:0] b);
      logic [15:0] nxt;
      nxt = {run_check[14:0], 1'b0};
      if (run_check[15]) begin
        nxt = nxt ^ poly;
      end
      run_check = nxt ^ {prev_rx, b};
      prev_rx   = b;
    endfunction

    function void expect_word(tfr_pkg::kind_t k, logic [7:0] d, logic [9:0] idx, logic l);
      deframe_word_t w;
      w.kind         = k;
      w.data_byte    = d;
      w.byte_index   = idx;
      w.address_byte = addr_held;
      w.frame_length = len_field;
      w.last         = l;
      due_words.push_back(w);
    endfunction

    // one accepted input word
    function void take_rx_word(logic [7:0] b, logic to);
      int i;
      n_rx++;
      if (to) begin
        expect_word(tfr_pkg::KIND_TIMEOUT, 8'h00, 10'd0, 1'b1);
        clear_frame();
        n_counted++;
        return;
      end
      case (ph)
        tfr_pkg::PH_HUNT: begin
          if (b == ack_byte || b == nack_byte) begin
            expect_word((b == ack_byte) ? tfr_pkg::KIND_ACK : tfr_pkg::KIND_NACK, b, 10'd0,
                        1'b1);
            clear_frame();
            n_counted++;
          end else if (!ack_only && hunt_buf[0] == sof_code && hunt_buf[1][7]) begin
            // window holds a header, the new byte is the command byte
            addr_held = hunt_buf[1];
            len_field = {hunt_buf[3], hunt_buf[2]};
            n_counted++;
            if ({1'b0, len_field} > tfr_pkg::MAX_LENGTH) begin
              expect_word(tfr_pkg::KIND_TOO_LONG, b, 10'd0, 1'b1);
              clear_frame();
            end else begin
              run_check = 16'h0000;
              prev_rx   = 8'h00;
              for (i = 0; i < 4; i++) feed_check(hunt_buf[i]);
              if (len_field != 16'h0000) feed_check(b);
              expect_word(tfr_pkg::KIND_BODY, b, 10'd0, 1'b0);
              body_pos = 16'd1;
              ph = (len_field > 16'd1) ? tfr_pkg::PH_BODY : tfr_pkg::PH_CHK_LO;
            end
          end else begin
            for (i = 0; i < 3; i++) hunt_buf[i] = hunt_buf[i+1];
            hunt_buf[3] = b;
          end
        end
        tfr_pkg::PH_BODY: begin
          feed_check(b);
          expect_word(tfr_pkg::KIND_BODY, b, body_pos[9:0], 1'b0);
          body_pos = body_pos + 16'd1;
          if (body_pos >= len_field) ph = tfr_pkg::PH_CHK_LO;
          n_counted++;
        end
        tfr_pkg::PH_CHK_LO: begin
          check_lo = b;
          ph = tfr_pkg::PH_CHK_HI;
          n_counted++;
        end
        default: begin
          expect_word(({b, check_lo} == run_check) ? tfr_pkg::KIND_GOOD
                                                   : tfr_pkg::KIND_CRC_BAD,
                      b, 10'd0, 1'b1);
          clear_frame();
          n_counted++;
        end
      endcase
    endfunction

    function void cmp_field(string what, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        n_fail++;
      end
    endfunction

    // one accepted result word against the oldest expectation
    function void check_out_word(logic [2:0] kind_bits, logic [47:0] tdata, logic tlast);
      deframe_word_t w;
      n_out++;
      if (kind_bits < 3'd7) kind_seen[kind_bits]++;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual kind %0d data %h",
                 $time, kind_bits, tdata);
        n_fail++;
        return;
      end
      w = due_words.pop_front();
      cmp_field("kind", 16'(w.kind), 16'(kind_bits));
      cmp_field("data_byte", 16'(w.data_byte), 16'(tdata[7:0]));
      cmp_field("byte_index", 16'(w.byte_index), 16'(tdata[17:8]));
      cmp_field("address_byte", 16'(w.address_byte), 16'(tdata[25:18]));
      cmp_field("frame_length", w.frame_length, tdata[41:26]);
      cmp_field("pad bits", 16'h0000, 16'(tdata[47:42]));
      cmp_field("last", 16'(w.last), 16'(tlast));
    endfunction
  endclass

  logic                          clk        = 1'b0;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = 8'h00;
  logic [0:0]                    in_tuser   = 1'b0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [47:0]                   out_tdata;
  logic [2:0]                    out_tuser;
  logic                          out_tlast;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [tfr_pkg::CFG_IDX_W-1:0] cfg_index  = tfr_pkg::CFG_START_CODE;
  logic [15:0]                   cfg_data   = 16'h0000;

  int unsigned tx_idle_pct = 34;
  int unsigned rx_idle_pct = 51;

  deframe_scoreboard sb;

  telegram_frame_receiver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_out_word(out_tuser, out_tdata, out_tlast);
    end
  end

  // one input word, then a random gap
  task automatic send_word(input logic [7:0] b, input logic to);
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tuser[0] <= to;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_rx_word(b, to);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // a frame word, or a timeout in its place when the frame is cut here
  task automatic frame_word(input logic [7:0] b, input bit abort, output bit gone);
    if (abort) begin
      send_word(8'($urandom), 1'b1);
    end else begin
      send_word(b, 1'b0);
    end
    gone = abort;
  endtask

  function automatic logic [7:0] body_byte();
    if ($urandom_range(7) == 0) begin
      return $urandom_range(1) ? sb.ack_byte : sb.nack_byte;
    end
    return 8'($urandom);
  endfunction

  // header, command and body, then the check bytes computed on the fly
  task automatic send_frame(input logic [15:0] len, input bit corrupt, input bit trunc);
    logic [7:0]  hdr [4];
    logic [15:0] chk;
    int unsigned cut, k, i;
    bit          gone;
    hdr[0] = sb.sof_code;
    hdr[1] = 8'h80 | 8'($urandom);
    hdr[2] = len[7:0];
    hdr[3] = len[15:8];
    cut = $urandom_range(0, (len > 16'd1020) ? 5 : int'(len) + 6);
    k = 0;
    for (i = 0; i < 4; i++) begin
      frame_word(hdr[i], trunc && k == cut, gone);
      k++;
      if (gone) return;
    end
    frame_word(8'($urandom), trunc && k == cut, gone);
    k++;
    if (gone) return;
    while (sb.ph == tfr_pkg::PH_BODY) begin
      frame_word(body_byte(), trunc && k == cut, gone);
      k++;
      if (gone) return;
    end
    if (sb.ph != tfr_pkg::PH_CHK_LO) return;
    chk = sb.run_check ^ (corrupt ? 16'($urandom_range(1, 65535)) : 16'h0000);
    frame_word(chk[7:0], trunc && k == cut, gone);
    k++;
    if (gone) return;
    frame_word(chk[15:8], trunc && k == cut, gone);
  endtask

  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(999);
    if (r < 100) return 16'd0;
    if (r < 200) return 16'd1;
    if (r < 750) return 16'($urandom_range(2, 12));
    if (r < 950) return 16'($urandom_range(13, 64));
    if (r < 960) return 16'd1021;
    if (r < 975) return 16'hffff;
    if (r < 990) return 16'($urandom_range(1022, 65535));
    return 16'd1020;
  endfunction

  // mostly frames with random content, the rest ack, nack, timeouts and noise
  task automatic run_traffic(input int unsigned target);
    int unsigned base, sel, n, i;
    base = sb.n_counted;
    while (sb.n_counted - base < target) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        send_frame(pick_len(), $urandom_range(99) < 15, $urandom_range(99) < 6);
      end else if (sel < 65) begin
        send_word($urandom_range(1) ? sb.ack_byte : sb.nack_byte, 1'b0);
      end else if (sel < 72) begin
        send_word(8'($urandom), 1'b1);
      end else begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
          send_word(($urandom_range(5) == 0) ? sb.sof_code : 8'($urandom), 1'b0);
        end
      end
    end
  endtask

  // stop sending and let every expected word come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [tfr_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic [7:0] sc, input logic [7:0] ac, input logic [7:0] nc,
                           input logic [15:0] pl, input logic mode);
    cfg_write(tfr_pkg::CFG_START_CODE, 16'(sc));
    cfg_write(tfr_pkg::CFG_ACK_CODE, 16'(ac));
    cfg_write(tfr_pkg::CFG_NACK_CODE, 16'(nc));
    cfg_write(tfr_pkg::CFG_CRC_POLY, pl);
    cfg_write(tfr_pkg::CFG_ACK_ONLY, 16'(mode));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int unsigned p;
    logic [7:0]  rs, ra, rn;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ack, nack, idle timeout, empty frame, codes inside a body,
    // bad check, oversized length
    send_word(tfr_pkg::ACK_CODE_RST, 1'b0);
    send_word(tfr_pkg::NACK_CODE_RST, 1'b0);
    send_word(8'hff, 1'b1);
    send_frame(16'd0, 1'b0, 1'b0);
    send_word(tfr_pkg::START_CODE_RST, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h03, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h10, 1'b0);
    send_word(tfr_pkg::ACK_CODE_RST, 1'b0);
    send_word(tfr_pkg::NACK_CODE_RST, 1'b0);
    send_word(sb.run_check[7:0] ^ 8'h01, 1'b0);
    send_word(sb.run_check[15:8], 1'b0);
    send_word(tfr_pkg::START_CODE_RST, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h5a, 1'b0);
    drain();

    // random phases under several settings
    for (p = 0; p < 6; p++) begin
      if (p < 2) begin
        tx_idle_pct = 34;
        rx_idle_pct = 51;
      end else if (p < 4) begin
        tx_idle_pct = 51;
        rx_idle_pct = 34;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: configure(tfr_pkg::START_CODE_RST, tfr_pkg::ACK_CODE_RST, tfr_pkg::NACK_CODE_RST,
                     tfr_pkg::CRC_POLY_RST, 1'b0);
        1: configure(8'h00, 8'hff, 8'hfe, 16'h0000, 1'b0);
        2: configure(8'hff, 8'h7f, 8'h80, 16'hffff, 1'b0);
        3: begin
          // ack-only switched on in the middle of a frame body
          configure(8'h3c, 8'hc3, 8'h5a, 16'h1021, 1'b0);
          send_word(8'h3c, 1'b0);
          send_word(8'h81, 1'b0);
          send_word(8'h06, 1'b0);
          send_word(8'h00, 1'b0);
          send_word(8'h11, 1'b0);
          send_word(8'h22, 1'b0);
          drain();
          configure(8'h3c, 8'h00, 8'hff, 16'h1021, 1'b1);
          while (sb.ph == tfr_pkg::PH_BODY) send_word(8'($urandom), 1'b0);
          send_word(sb.run_check[7:0], 1'b0);
          send_word(sb.run_check[15:8], 1'b0);
        end
        default: begin
          rs = 8'($urandom);
          ra = 8'($urandom);
          while (ra == rs) ra = 8'($urandom);
          rn = 8'($urandom);
          while (rn == rs || rn == ra) rn = 8'($urandom);
          configure(rs, ra, rn, 16'($urandom), 1'b0);
        end
      endcase
      run_traffic((p == 3) ? 90 : 180);
      drain();
    end

    repeat (16) @(posedge clk);
    $display("run covered %0d input words (%0d past plain hunting) and %0d result words",
             sb.n_rx, sb.n_counted, sb.n_out);
    $display("verdicts: %0d good, %0d check errors, %0d too long, %0d timeouts",
             sb.kind_seen[tfr_pkg::KIND_GOOD], sb.kind_seen[tfr_pkg::KIND_CRC_BAD],
             sb.kind_seen[tfr_pkg::KIND_TOO_LONG], sb.kind_seen[tfr_pkg::KIND_TIMEOUT]);
    $display("          %0d ack, %0d nack",
             sb.kind_seen[tfr_pkg::KIND_ACK], sb.kind_seen[tfr_pkg::KIND_NACK]);
    if (sb.n_fail == 0 && sb.due_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
